@@ rtl/core/skt_pkg.sv @@
package skt_pkg;

   localparam int DEF_CAPACITY  = 32;
   localparam int DEF_KEY_BYTES = 8;

   localparam int FIELD_W  = 64;
   localparam int STATUS_W = 3;
   localparam int POS_OUT_W = 6;

   localparam logic ACT_LOCATE = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   // Compare outcome of one cell against the key under test.
   typedef struct packed {
      logic less;
      logic equal;
   } skt_match_type;

endpackage

@@ rtl/core/sorted_key_table_core.sv @@
// A transaction accepted at a clock edge is registered in busy_ff and then in
// rsp_valid_ff, which strobes its result on rsp_valid.
// No new transaction is taken while busy is high; busy is high for the single
// cycle in which the cell chain compares every entry and shifts on insert.
// Reset clears the fill count and the control state; stored entries keep their
// contents. The receiver cannot stall, so results are never held back.
module sorted_key_table_core import skt_pkg::*; #(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int KEY_BYTES = DEF_KEY_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [FIELD_W-1:0]   req_search_key,
   input  logic [FIELD_W-1:0]   req_entry_payload,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [POS_OUT_W-1:0] rsp_position,
   output logic [FIELD_W-1:0]   rsp_found_payload
);

   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = (CNT_W > POS_OUT_W) ? CNT_W : POS_OUT_W;

   logic                 busy_ff;
   logic                 rsp_valid_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 action_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [FIELD_W-1:0]   payload_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [STATUS_W-1:0]  status_in;
   logic [POS_OUT_W-1:0] position_ff;
   logic [FIELD_W-1:0]   found_ff;
   logic [FIELD_W-1:0]   found_in;

   logic [KEY_W-1:0]     canon_key;
   logic                 accept;
   logic                 hit;
   logic                 full;
   logic                 insert_en;
   logic [CNT_W-1:0]     pos;
   logic [EXT_W-1:0]     pos_ext;
   logic [FIELD_W-1:0]   hit_payload_any;

   skt_match_type        match     [CAPACITY];
   logic [KEY_W-1:0]     cell_key  [CAPACITY];
   logic [FIELD_W-1:0]   cell_pay  [CAPACITY];
   logic [FIELD_W-1:0]   cell_hit  [CAPACITY];

   assign accept = start && !busy_ff;

   // Keep the low KEY_BYTES bytes and clear everything after the first NUL,
   // so that unsigned compare gives string order.
   always_comb begin
      logic ended;
      ended     = 1'b0;
      canon_key = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (req_search_key[8*(KEY_BYTES-1-b) +: 8] == 8'd0) begin
            ended = 1'b1;
         end
         if (!ended) begin
            canon_key[8*(KEY_BYTES-1-b) +: 8] = req_search_key[8*(KEY_BYTES-1-b) +: 8];
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               left_less;
      logic [KEY_W-1:0]   left_key;
      logic [FIELD_W-1:0] left_payload;

      if (i == 0) begin : g_head
         assign left_less    = 1'b1;
         assign left_key     = key_ff;
         assign left_payload = payload_ff;
      end else begin : g_body
         assign left_less    = match[i-1].less;
         assign left_key     = cell_key[i-1];
         assign left_payload = cell_pay[i-1];
      end

      skt_cell #(
         .KEY_W (KEY_W)
      ) u_cell (
         .clock        (clock),
         .entry_valid  (CNT_W'(i) < count_ff),
         .req_key      (key_ff),
         .req_payload  (payload_ff),
         .insert_en    (insert_en),
         .left_less    (left_less),
         .left_key     (left_key),
         .left_payload (left_payload),
         .match        (match[i]),
         .key_out      (cell_key[i]),
         .payload_out  (cell_pay[i]),
         .hit_payload  (cell_hit[i])
      );
   end

   // The less flags form a run of ones from cell zero; the position is where
   // the run ends.
   always_comb begin
      logic prev_less;
      logic cur_less;
      hit             = 1'b0;
      hit_payload_any = '0;
      pos             = '0;
      for (int i = 0; i <= CAPACITY; i++) begin
         prev_less = (i == 0) ? 1'b1 : match[i-1].less;
         cur_less  = (i == CAPACITY) ? 1'b0 : match[i].less;
         if (prev_less && !cur_less) begin
            pos = pos | CNT_W'(i);
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         hit             = hit | match[i].equal;
         hit_payload_any = hit_payload_any | cell_hit[i];
      end
   end

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign insert_en = busy_ff && (action_ff == ACT_INSERT) && !hit && !full;
   assign pos_ext   = EXT_W'(pos);

   always_comb begin
      found_in = '0;
      priority if (action_ff == ACT_LOCATE) begin
         status_in = hit ? ST_FOUND : ST_NOT_FOUND;
         found_in  = hit ? hit_payload_any : '0;
      end else if (hit) begin
         status_in = ST_DUPLICATE;
      end else if (full) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_INSERTED;
      end
      count_in = insert_en ? count_ff + CNT_W'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff  <= req_action;
         key_ff     <= canon_key;
         payload_ff <= req_entry_payload;
      end
      if (busy_ff) begin
         status_ff   <= status_in;
         position_ff <= pos_ext[POS_OUT_W-1:0];
         found_ff    <= found_in;
      end
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_position      = position_ff;
   assign rsp_found_payload = found_ff;

endmodule

@@ rtl/core/skt_cell.sv @@
module skt_cell import skt_pkg::*; #(
   parameter int KEY_W = 64
) (
   input  logic               clock,
   input  logic               entry_valid,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [FIELD_W-1:0] req_payload,
   input  logic               insert_en,
   input  logic               left_less,
   input  logic [KEY_W-1:0]   left_key,
   input  logic [FIELD_W-1:0] left_payload,
   output skt_match_type      match,
   output logic [KEY_W-1:0]   key_out,
   output logic [FIELD_W-1:0] payload_out,
   output logic [FIELD_W-1:0] hit_payload
);

   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;
   logic [FIELD_W-1:0] payload_ff;
   logic [FIELD_W-1:0] payload_in;

   always_comb begin
      match.less  = entry_valid && (key_ff < req_key);
      match.equal = entry_valid && (key_ff == req_key);
   end

   // A cell above the insertion point takes its left neighbor's entry;
   // the cell right at the insertion point takes the new entry.
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (insert_en && !match.less) begin
         key_in     = left_less ? req_key : left_key;
         payload_in = left_less ? req_payload : left_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key_out     = key_ff;
   assign payload_out = payload_ff;
   assign hit_payload = match.equal ? payload_ff : '0;

endmodule

@@ rtl/core/skt_checker.sv @@
module skt_checker import skt_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [FIELD_W-1:0]   rsp_found_payload
);

   // An accepted transaction raises busy; busy is followed by a result strobe with busy low again.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("busy cycle not followed by a single result");

   a_result_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding busy cycle");

   // Only a locate hit carries payload data.
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_FOUND)) |-> (rsp_found_payload == '0))
      else $error("payload returned on a result other than found");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_INSERTED || rsp_status == ST_DUPLICATE ||
                     rsp_status == ST_FULL || rsp_status == ST_FOUND ||
                     rsp_status == ST_NOT_FOUND))
      else $error("result carries an unknown status code");

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_found_payload (rsp_found_payload)
);

@@ tb/sorted_key_table_core_tb.sv @@
`timescale 1ns / 1ps

module sorted_key_table_core_tb;
   import skt_pkg::*;

   localparam int CAPACITY     = DEF_CAPACITY;
   localparam int KEY_BYTES    = DEF_KEY_BYTES;
   localparam int RANDOM_ITEMS = 1900;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 4;
   localparam int NUM_DIRECTED = 18;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [POS_OUT_W-1:0] position;
      logic [FIELD_W-1:0]   found_payload;
   } lookup_result_type;

   typedef struct packed {
      logic                 action;
      logic [FIELD_W-1:0]   key;
      logic [FIELD_W-1:0]   payload;
      logic                 fixed;
      lookup_result_type    result;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_action;
   logic [FIELD_W-1:0]   req_search_key;
   logic [FIELD_W-1:0]   req_entry_payload;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [POS_OUT_W-1:0] rsp_position;
   logic [FIELD_W-1:0]   rsp_found_payload;

   // Shadow copy of the sorted table.
   int                 table_fill;
   logic [FIELD_W-1:0] table_keys [CAPACITY];
   logic [FIELD_W-1:0] table_payloads [CAPACITY];

   lookup_result_type pending_results[$];
   directed_row_type  directed_rows [NUM_DIRECTED];
   int                mismatch_count = 0;
   int                stall_cycles = 0;
   int                burst_left = 0;

   sorted_key_table_core #(
      .CAPACITY  (CAPACITY),
      .KEY_BYTES (KEY_BYTES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_search_key    (req_search_key),
      .req_entry_payload (req_entry_payload),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_position      (rsp_position),
      .rsp_found_payload (rsp_found_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Keys compare like C strings: everything after the first NUL byte is dropped.
   function automatic logic [FIELD_W-1:0] canonical_key(input logic [FIELD_W-1:0] raw);
      logic [FIELD_W-1:0] canon;
      logic               ended;
      logic [7:0]         b;
      canon = '0;
      ended = 1'b0;
      for (int i = KEY_BYTES - 1; i >= 0; i--) begin
         b = raw[8*i +: 8];
         if (b == 8'h00)
            ended = 1'b1;
         if (!ended)
            canon[8*i +: 8] = b;
      end
      return canon;
   endfunction

   function automatic lookup_result_type apply_table_op(input logic act,
                                                       input logic [FIELD_W-1:0] raw_key,
                                                       input logic [FIELD_W-1:0] payload);
      lookup_result_type  res;
      logic [FIELD_W-1:0] key;
      int                 idx;
      logic               hit;
      key = canonical_key(raw_key);
      idx = 0;
      while (idx < table_fill && table_keys[idx] < key)
         idx++;
      hit = (idx < table_fill) && (table_keys[idx] == key);
      res.found_payload = '0;
      res.position = POS_OUT_W'(idx);
      if (act == ACT_LOCATE) begin
         if (hit) begin
            res.status = ST_FOUND;
            res.found_payload = table_payloads[idx];
         end else begin
            res.status = ST_NOT_FOUND;
         end
      end else if (hit) begin
         res.status = ST_DUPLICATE;
      end else if (table_fill >= CAPACITY) begin
         res.status = ST_FULL;
      end else begin
         for (int i = table_fill; i > idx; i--) begin
            table_keys[i] = table_keys[i-1];
            table_payloads[i] = table_payloads[i-1];
         end
         table_keys[idx] = key;
         table_payloads[idx] = payload;
         table_fill++;
         res.status = ST_INSERTED;
      end
      return res;
   endfunction

   // Same string as k, with random bytes after its terminating NUL.
   function automatic logic [FIELD_W-1:0] alias_key(input logic [FIELD_W-1:0] k);
      logic [FIELD_W-1:0] out;
      logic               ended;
      out = k;
      ended = 1'b0;
      for (int i = KEY_BYTES - 1; i >= 0; i--) begin
         if (ended)
            out[8*i +: 8] = 8'($urandom);
         else if (k[8*i +: 8] == 8'h00)
            ended = 1'b1;
      end
      return out;
   endfunction

   function automatic logic [FIELD_W-1:0] pick_key(input int mode);
      logic [FIELD_W-1:0] k;
      logic [FIELD_W-1:0] stored;
      k = {$urandom, $urandom};
      if (table_fill > 0)
         stored = table_keys[$urandom_range(0, table_fill - 1)];
      else
         stored = k;
      case (mode)
         1: k[8*$urandom_range(0, 7) +: 8] = 8'h00;
         2: begin
            // A small alphabet makes near misses and shared prefixes common.
            for (int i = 0; i < 8; i++) begin
               case ($urandom_range(0, 7))
                  0: k[8*i +: 8] = 8'h00;
                  1: k[8*i +: 8] = 8'h01;
                  2: k[8*i +: 8] = 8'h41;
                  3: k[8*i +: 8] = 8'h42;
                  4: k[8*i +: 8] = 8'h7F;
                  5: k[8*i +: 8] = 8'h80;
                  6: k[8*i +: 8] = 8'hFE;
                  default: k[8*i +: 8] = 8'hFF;
               endcase
            end
         end
         3: k = alias_key(stored);
         4: k = $urandom_range(0, 1) ? stored + 64'd1 : stored - 64'd1;
         default: ;
      endcase
      return k;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 149) == 0)
         burst_left = 40;
      if (roll < 50)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic issue_op(input logic act, input logic [FIELD_W-1:0] key,
                           input logic [FIELD_W-1:0] payload, input logic fixed,
                           input lookup_result_type fixed_result);
      lookup_result_type predicted;
      int                gap;
      req_action <= act;
      req_search_key <= key;
      req_entry_payload <= payload;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      // The transaction is taken at this edge.
      predicted = apply_table_op(act, key, payload);
      pending_results.push_back(fixed ? fixed_result : predicted);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d position %0d", rsp_status, rsp_position);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               mismatch_count++;
            end
            if (rsp_found_payload !== want.found_payload) begin
               $error("found_payload: expected %h, got %h",
                      want.found_payload, rsp_found_payload);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int roll;
      directed_rows = '{
         '{ACT_LOCATE, 64'h0, 64'h0, 1'b1, '{ST_NOT_FOUND, 6'd0, 64'h0}},
         '{ACT_LOCATE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, '{ST_NOT_FOUND, 6'd0, 64'h0}},
         '{ACT_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_INSERTED, 6'd0, 64'h0}},
         '{ACT_INSERT, 64'h00FF_FFFF_FFFF_FFFF, 64'h1234, 1'b1, '{ST_DUPLICATE, 6'd0, 64'h0}},
         '{ACT_LOCATE, 64'h0012_3456_789A_BCDE, 64'h0, 1'b1,
           '{ST_FOUND, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF}},
         '{ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, '{ST_INSERTED, 6'd1, 64'h0}},
         '{ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5, 1'b1, '{ST_DUPLICATE, 6'd1, 64'h0}},
         '{ACT_LOCATE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, '{ST_FOUND, 6'd1, 64'h0}},
         '{ACT_INSERT, 64'h8000_0000_0000_0000, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1,
           '{ST_INSERTED, 6'd1, 64'h0}},
         '{ACT_LOCATE, 64'h8000_0000_0000_0001, 64'h0, 1'b0, '0},
         '{ACT_INSERT, 64'h4142_0043_4445_4647, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0},
         '{ACT_LOCATE, 64'h4142_0000_0000_0000, 64'h0, 1'b0, '0},
         '{ACT_LOCATE, 64'h4142_4300_0000_0000, 64'h0, 1'b0, '0},
         '{ACT_INSERT, 64'h0100_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
         '{ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
         '{ACT_LOCATE, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0, 1'b0, '0},
         '{ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001, 1'b0, '0},
         '{ACT_LOCATE, 64'h0101_0101_0101_0101, 64'h0, 1'b0, '0}
      };
      table_fill = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= ACT_LOCATE;
      req_search_key <= '0;
      req_entry_payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         issue_op(directed_rows[i].action, directed_rows[i].key, directed_rows[i].payload,
                  directed_rows[i].fixed, directed_rows[i].result);

      // While the table fills, most transactions insert new keys; once it is
      // full, hits, duplicates and refused inserts dominate.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (table_fill < CAPACITY) begin
            if (roll < 65)
               issue_op(ACT_INSERT, pick_key($urandom_range(0, 2) == 0 ? 4 :
                        $urandom_range(0, 2)), {$urandom, $urandom}, 1'b0, '0);
            else if (roll < 80)
               issue_op(ACT_LOCATE, pick_key(3), {$urandom, $urandom}, 1'b0, '0);
            else if (roll < 90)
               issue_op(ACT_LOCATE, pick_key($urandom_range(0, 4)), {$urandom, $urandom},
                        1'b0, '0);
            else
               issue_op(ACT_INSERT, pick_key(3), {$urandom, $urandom}, 1'b0, '0);
         end else begin
            if (roll < 35)
               issue_op(ACT_LOCATE, pick_key(3), {$urandom, $urandom}, 1'b0, '0);
            else if (roll < 55)
               issue_op(ACT_LOCATE, pick_key($urandom_range(0, 4)), {$urandom, $urandom},
                        1'b0, '0);
            else if (roll < 75)
               issue_op(ACT_INSERT, pick_key(3), {$urandom, $urandom}, 1'b0, '0);
            else
               issue_op(ACT_INSERT, pick_key($urandom_range(0, 4)), {$urandom, $urandom},
                        1'b0, '0);
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/sorted_key_table_core.sv
rtl/core/skt_checker.sv
tb/sorted_key_table_core_tb.sv
